[hdl/ree_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raft election endpoint package
// Shared types, codes, reset values and helper functions for the endpoint.
// ----------------------------------------------------------------------------
package ree_pkg;

   // Default parameter values
   localparam int MAX_NODES_DEFAULT = 8;
   localparam int TERM_BITS_DEFAULT = 32;

   // Vote map covers every 3-bit node identifier
   localparam int MAP_BITS = 8;

   // Depth of the queue between front and back end
   localparam int JOB_QUEUE_DEPTH = 2;

   // Register reset values
   localparam logic [2:0]  NODE_ID_RESET      = 3'd0;
   localparam logic [3:0]  CLUSTER_SIZE_RESET = 4'd3;
   localparam logic [23:0] ELECTION_TO_RESET  = 24'd150;
   localparam logic [15:0] HB_INTERVAL_RESET  = 16'd50;

   // Input event codes
   typedef enum logic [2:0] {
      MODE_TICK     = 3'd0,
      MODE_VOTE_REQ = 3'd1,
      MODE_HB_REQ   = 3'd2,
      MODE_VOTE_RSP = 3'd3,
      MODE_HB_RSP   = 3'd4
   } mode_type;

   // Outgoing message kinds
   typedef enum logic [1:0] {
      KIND_VOTE_RSP = 2'd0,
      KIND_HB_RSP   = 2'd1,
      KIND_VOTE_REQ = 2'd2,
      KIND_HB       = 2'd3
   } kind_type;

   // Node roles
   typedef enum logic [1:0] {
      ROLE_FOLLOWER  = 2'd0,
      ROLE_CANDIDATE = 2'd1,
      ROLE_LEADER    = 2'd2
   } role_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_NODE_ID       = 3'd0,
      CSR_CLUSTER_SIZE  = 3'd1,
      CSR_ELECTION_TO   = 3'd2,
      CSR_HB_INTERVAL   = 3'd3,
      CSR_OWN_LAST_IDX  = 3'd4,
      CSR_OWN_LAST_TERM = 3'd5
   } csr_index_type;

   // Configuration register set
   typedef struct packed {
      logic [2:0]  node_id;
      logic [3:0]  cluster_size;
      logic [23:0] election_timeout;
      logic [15:0] heartbeat_interval;
      logic [31:0] own_last_index;
      logic [31:0] own_last_term;
   } cfg_type;

   // Work handed from front end to back end: one reply or one fan-out round
   typedef struct packed {
      kind_type    kind;
      logic        fan;
      logic [2:0]  dest;
      logic        ok;
      logic [31:0] term;
      role_type    role;
      logic [3:0]  size;
      logic [2:0]  me;
   } job_type;

   // Effective cluster size: clamp to [1, cap], grow to cover own id
   function automatic logic [3:0] eff_size(input logic [3:0] cluster_size,
                                           input logic [2:0] node_id,
                                           input logic [3:0] cap);
      logic [3:0] n;
      n = cluster_size;
      if (n == 4'd0) n = 4'd1;
      if (n > cap) n = cap;
      if ({1'b0, node_id} >= n) n = {1'b0, node_id} + 4'd1;
      return n;
   endfunction

   // Strict majority of the first n vote bits
   function automatic logic majority(input logic [MAP_BITS-1:0] map,
                                     input logic [3:0] n);
      logic [3:0] c;
      c = 4'd0;
      for (int i = 0; i < MAP_BITS; i++) begin
         if (4'(i) < n) c = c + 4'(map[i]);
      end
      return c > (n >> 1);
   endfunction

endpackage

[hdl/ree_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Small register FIFO decoupling the event front end from the message back end.
// ----------------------------------------------------------------------------
module ree_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

[hdl/ree_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Election front end
// Takes one event per cycle while accept is high, updates role, term, votes
// and timers, and queues a job describing the messages the event causes.
// ----------------------------------------------------------------------------
module ree_front #(
   parameter int MAX_NODES = ree_pkg::MAX_NODES_DEFAULT,
   parameter int TERM_BITS = ree_pkg::TERM_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [2:0]        mode,
   input  logic [31:0]       msg_term,
   input  logic [2:0]        sender_id,
   input  logic              granted,
   input  logic [31:0]       cand_last_index,
   input  logic [31:0]       cand_last_term,
   input  ree_pkg::cfg_type  cfg,
   output logic              job_push,
   output ree_pkg::job_type  job
);

   localparam logic [3:0] NODE_CAP = (MAX_NODES < 8) ? 4'(MAX_NODES) : 4'd8;
   localparam int MB = ree_pkg::MAP_BITS;

   ree_pkg::role_type    role_ff, role_in, s_role;
   logic [TERM_BITS-1:0] term_ff, term_in, s_term, mterm;
   logic                 voted_ff, voted_in, s_voted;
   logic [2:0]           vnode_ff, vnode_in;
   logic [MB-1:0]        map_ff, map_in, s_map, map_new;
   logic [23:0]          ec_ff, ec_in, s_ec, ec_inc;
   logic [15:0]          hb_ff, hb_in, hb_inc;
   logic [3:0]           eff;
   logic                 higher, not_lower, free, fresh, event_ok;
   ree_pkg::mode_type    mode_e;

   assign mode_e = ree_pkg::mode_type'(mode);

   // Event decode and state update
   always_comb begin
      mterm     = TERM_BITS'(msg_term);
      higher    = mterm > term_ff;
      not_lower = mterm >= term_ff;
      eff       = ree_pkg::eff_size(cfg.cluster_size, cfg.node_id, NODE_CAP);
      ec_inc    = (ec_ff != '1) ? ec_ff + 24'd1 : ec_ff;
      hb_inc    = (hb_ff != '1) ? hb_ff + 16'd1 : hb_ff;
      free      = 1'b0;
      fresh     = 1'b0;
      event_ok  = 1'b0;
      map_new   = map_ff;

      // higher term in any message: adopt it and fall back to follower
      s_role  = role_ff;
      s_term  = term_ff;
      s_voted = voted_ff;
      s_map   = map_ff;
      s_ec    = ec_ff;
      if (mode_e inside {[ree_pkg::MODE_VOTE_REQ:ree_pkg::MODE_HB_RSP]} && higher) begin
         s_term  = mterm;
         s_voted = 1'b0;
         s_map   = '0;
         if (role_ff != ree_pkg::ROLE_FOLLOWER) s_ec = '0;
         s_role  = ree_pkg::ROLE_FOLLOWER;
      end

      role_in  = s_role;
      term_in  = s_term;
      voted_in = s_voted;
      vnode_in = vnode_ff;
      map_in   = s_map;
      ec_in    = s_ec;
      hb_in    = hb_ff;

      job_push = 1'b0;
      job.kind = ree_pkg::KIND_VOTE_RSP;
      job.fan  = 1'b0;
      job.dest = sender_id;
      job.ok   = 1'b0;

      case (mode_e)
         ree_pkg::MODE_TICK: begin
            if (role_ff == ree_pkg::ROLE_LEADER) begin
               // heartbeat round timer
               if (hb_inc >= cfg.heartbeat_interval) begin
                  hb_in    = '0;
                  job.kind = ree_pkg::KIND_HB;
                  job.fan  = 1'b1;
                  job_push = (eff > 4'd1);
               end else begin
                  hb_in = hb_inc;
               end
            end else if (ec_inc >= cfg.election_timeout) begin
               // election timeout: new term, vote for self
               term_in  = (term_ff != '1) ? term_ff + TERM_BITS'(1) : term_ff;
               voted_in = 1'b1;
               vnode_in = cfg.node_id;
               map_in   = MB'(1) << cfg.node_id;
               ec_in    = '0;
               job.fan  = 1'b1;
               if (ree_pkg::majority(map_in, eff)) begin
                  role_in  = ree_pkg::ROLE_LEADER;
                  hb_in    = '0;
                  job.kind = ree_pkg::KIND_HB;
               end else begin
                  role_in  = ree_pkg::ROLE_CANDIDATE;
                  job.kind = ree_pkg::KIND_VOTE_REQ;
               end
               job_push = (eff > 4'd1);
            end else begin
               ec_in = ec_inc;
            end
         end
         ree_pkg::MODE_VOTE_REQ: begin
            // up-to-date rule on the candidate's log
            free  = !s_voted || (vnode_ff == sender_id);
            fresh = (cand_last_term > cfg.own_last_term) ||
                    ((cand_last_term == cfg.own_last_term) &&
                     (cand_last_index >= cfg.own_last_index));
            if (not_lower && free && fresh) begin
               event_ok = 1'b1;
               voted_in = 1'b1;
               vnode_in = sender_id;
               ec_in    = '0;
            end
            job.kind = ree_pkg::KIND_VOTE_RSP;
            job.ok   = event_ok;
            job_push = 1'b1;
         end
         ree_pkg::MODE_HB_REQ: begin
            if (not_lower) begin
               event_ok = 1'b1;
               role_in  = ree_pkg::ROLE_FOLLOWER;
               map_in   = '0;
               ec_in    = '0;
            end
            job.kind = ree_pkg::KIND_HB_RSP;
            job.ok   = event_ok;
            job_push = 1'b1;
         end
         ree_pkg::MODE_VOTE_RSP: begin
            // not_lower after step-down means equal terms
            if (s_role == ree_pkg::ROLE_CANDIDATE && not_lower && granted) begin
               map_new = s_map;
               if ({1'b0, sender_id} < eff) map_new = s_map | (MB'(1) << sender_id);
               map_in = map_new;
               if (ree_pkg::majority(map_new, eff)) begin
                  role_in  = ree_pkg::ROLE_LEADER;
                  hb_in    = '0;
                  job.kind = ree_pkg::KIND_HB;
                  job.fan  = 1'b1;
                  job_push = (eff > 4'd1);
               end
            end
         end
         ree_pkg::MODE_HB_RSP: begin
            // acts only through the term check above
         end
         default: begin
            // unknown event: nothing changes
            role_in  = role_ff;
            term_in  = term_ff;
            voted_in = voted_ff;
            map_in   = map_ff;
            ec_in    = ec_ff;
         end
      endcase

      job.term = 32'(term_in);
      job.role = role_in;
      job.size = eff;
      job.me   = cfg.node_id;
      job_push = job_push && accept;
   end

   // Node state
   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff  <= ree_pkg::ROLE_FOLLOWER;
         term_ff  <= '0;
         voted_ff <= 1'b0;
         vnode_ff <= '0;
         map_ff   <= '0;
         ec_ff    <= '0;
         hb_ff    <= '0;
      end else if (accept) begin
         role_ff  <= role_in;
         term_ff  <= term_in;
         voted_ff <= voted_in;
         vnode_ff <= vnode_in;
         map_ff   <= map_in;
         ec_ff    <= ec_in;
         hb_ff    <= hb_in;
      end
   end

endmodule

[hdl/ree_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message back end
// Expands each queued job into result register messages, one per cycle while
// that register is free or popped, walking the peer list for fan-out rounds.
// ----------------------------------------------------------------------------
module ree_back (
   input  logic              clock,
   input  logic              reset,
   input  ree_pkg::job_type  job,
   input  logic              job_valid,
   output logic              job_pop,
   input  ree_pkg::cfg_type  cfg,
   input  logic              out_pop,
   output logic              out_valid,
   output logic [1:0]        out_kind,
   output logic [2:0]        out_dest_id,
   output logic [31:0]       out_term,
   output logic              out_ok_flag,
   output logic [31:0]       out_last_index,
   output logic [31:0]       out_last_term,
   output logic [1:0]        out_role_now,
   output logic              out_last_of_run
);

   logic        valid_ff, valid_in;
   logic [2:0]  cursor_ff, cursor_in;
   logic        advance, last;
   logic [2:0]  dest;
   logic [3:0]  nxt;
   logic        is_vreq;

   logic [1:0]  kind_ff;
   logic [2:0]  dest_ff;
   logic [31:0] term_ff;
   logic        ok_ff;
   logic [31:0] li_ff;
   logic [31:0] lt_ff;
   logic [1:0]  role_ff;
   logic        last_ff;

   // Next peer of the round, skipping own id
   always_comb begin
      advance = job_valid && (!valid_ff || out_pop);
      dest    = job.fan ? ((cursor_ff == job.me) ? cursor_ff + 3'd1 : cursor_ff) : job.dest;
      nxt     = {1'b0, dest} + 4'd1;
      last    = !job.fan || (nxt >= job.size) ||
                ((nxt == {1'b0, job.me}) && (nxt + 4'd1 >= job.size));
      job_pop = advance && last;
      is_vreq = (job.kind == ree_pkg::KIND_VOTE_REQ);

      cursor_in = cursor_ff;
      if (advance) cursor_in = last ? 3'd0 : nxt[2:0];

      valid_in = valid_ff;
      if (advance) valid_in = 1'b1;
      else if (out_pop) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         cursor_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         cursor_ff <= cursor_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff <= job.kind;
         dest_ff <= dest;
         term_ff <= job.term;
         ok_ff   <= job.fan ? 1'b0 : job.ok;
         li_ff   <= is_vreq ? cfg.own_last_index : 32'd0;
         lt_ff   <= is_vreq ? cfg.own_last_term : 32'd0;
         role_ff <= job.role;
         last_ff <= last;
      end
   end

   assign out_valid       = valid_ff;
   assign out_kind        = kind_ff;
   assign out_dest_id     = dest_ff;
   assign out_term        = term_ff;
   assign out_ok_flag     = ok_ff;
   assign out_last_index  = li_ff;
   assign out_last_term   = lt_ff;
   assign out_role_now    = role_ff;
   assign out_last_of_run = last_ff;

endmodule

[hdl/raft_election_endpoint.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raft election endpoint
// Leader-election logic of one Raft node: roles, terms, votes and timers.
// ----------------------------------------------------------------------------
// One event (tick, vote request, heartbeat request, vote reply, heartbeat
// reply) is accepted per clock while the two-entry job queue has room; the
// front end updates the node state in the accepting cycle. The back end
// issues one outgoing message per cycle into the result register when it is
// empty or being popped; a reply is one message, a fan-out round one per peer
// (effective cluster size minus one, up to seven). An event's first result
// passes the job queue, then the result register. Configuration writes are
// always ready and must only be made while no event is in flight.
module raft_election_endpoint #(
   parameter int MAX_NODES = ree_pkg::MAX_NODES_DEFAULT,
   parameter int TERM_BITS = ree_pkg::TERM_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // event input
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_msg_term,
   input  logic [2:0]  req_sender_id,
   input  logic        req_granted,
   input  logic [31:0] req_cand_last_index,
   input  logic [31:0] req_cand_last_term,
   // outgoing messages
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_dest_id,
   output logic [31:0] rsp_out_term,
   output logic        rsp_ok_flag,
   output logic [31:0] rsp_out_last_index,
   output logic [31:0] rsp_out_last_term,
   output logic [1:0]  rsp_role_now,
   output logic        rsp_last_of_run,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int JOB_W = $bits(ree_pkg::job_type);

   ree_pkg::cfg_type cfg_ff;
   ree_pkg::job_type job_wr, job_rd;
   logic             job_push, job_pop, job_full, job_empty;
   logic             accept, out_valid;

   assign accept    = push && !job_full;
   assign full      = job_full;
   assign empty     = !out_valid;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_id            <= ree_pkg::NODE_ID_RESET;
         cfg_ff.cluster_size       <= ree_pkg::CLUSTER_SIZE_RESET;
         cfg_ff.election_timeout   <= ree_pkg::ELECTION_TO_RESET;
         cfg_ff.heartbeat_interval <= ree_pkg::HB_INTERVAL_RESET;
         cfg_ff.own_last_index     <= '0;
         cfg_ff.own_last_term      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (ree_pkg::csr_index_type'(csr_index))
            ree_pkg::CSR_NODE_ID:       cfg_ff.node_id            <= csr_data[2:0];
            ree_pkg::CSR_CLUSTER_SIZE:  cfg_ff.cluster_size       <= csr_data[3:0];
            ree_pkg::CSR_ELECTION_TO:   cfg_ff.election_timeout   <= csr_data[23:0];
            ree_pkg::CSR_HB_INTERVAL:   cfg_ff.heartbeat_interval <= csr_data[15:0];
            ree_pkg::CSR_OWN_LAST_IDX:  cfg_ff.own_last_index     <= csr_data;
            ree_pkg::CSR_OWN_LAST_TERM: cfg_ff.own_last_term      <= csr_data;
            default: ;
         endcase
      end
   end

   // Front end: event classification and node state
   ree_front #(
      .MAX_NODES (MAX_NODES),
      .TERM_BITS (TERM_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .mode            (req_mode),
      .msg_term        (req_msg_term),
      .sender_id       (req_sender_id),
      .granted         (req_granted),
      .cand_last_index (req_cand_last_index),
      .cand_last_term  (req_cand_last_term),
      .cfg             (cfg_ff),
      .job_push        (job_push),
      .job             (job_wr)
   );

   // Job queue between the two ends
   ree_queue #(
      .WIDTH (JOB_W),
      .DEPTH (ree_pkg::JOB_QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_wr),
      .pop     (job_pop),
      .rd_data (job_rd),
      .full    (job_full),
      .empty   (job_empty)
   );

   // Back end: message generation
   ree_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job             (job_rd),
      .job_valid       (!job_empty),
      .job_pop         (job_pop),
      .cfg             (cfg_ff),
      .out_pop         (pop && out_valid),
      .out_valid       (out_valid),
      .out_kind        (rsp_kind),
      .out_dest_id     (rsp_dest_id),
      .out_term        (rsp_out_term),
      .out_ok_flag     (rsp_ok_flag),
      .out_last_index  (rsp_out_last_index),
      .out_last_term   (rsp_out_last_term),
      .out_role_now    (rsp_role_now),
      .out_last_of_run (rsp_last_of_run)
   );

   // Vote requests only ever leave a candidate
   a_vreq_role: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == ree_pkg::KIND_VOTE_REQ) |-> rsp_role_now == ree_pkg::ROLE_CANDIDATE)
      else $error("vote request sent while not candidate");

   // Heartbeats only ever leave a leader
   a_hb_role: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind == ree_pkg::KIND_HB) |-> rsp_role_now == ree_pkg::ROLE_LEADER)
      else $error("heartbeat sent while not leader");

   // The ok flag is set on replies only
   a_ok_reply: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_ok_flag) |->
         (rsp_kind == ree_pkg::KIND_VOTE_RSP || rsp_kind == ree_pkg::KIND_HB_RSP))
      else $error("ok flag set on a request");

   // Log position is carried in vote requests only
   a_log_pos: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind != ree_pkg::KIND_VOTE_REQ) |->
         (rsp_out_last_index == 32'd0 && rsp_out_last_term == 32'd0))
      else $error("log position in a message that is not a vote request");

endmodule

[tb/raft_election_endpoint_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raft election endpoint checker
// Watches the event, message and register channels of the endpoint, keeps
// its own copy of the node's role, term, vote and timers, and compares each
// outgoing message field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module raft_election_endpoint_checker
   import ree_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_msg_term,
   input  logic [2:0]  req_sender_id,
   input  logic        req_granted,
   input  logic [31:0] req_cand_last_index,
   input  logic [31:0] req_cand_last_term,
   input  logic        empty,
   input  logic        pop,
   input  logic [1:0]  rsp_kind,
   input  logic [2:0]  rsp_dest_id,
   input  logic [31:0] rsp_out_term,
   input  logic        rsp_ok_flag,
   input  logic [31:0] rsp_out_last_index,
   input  logic [31:0] rsp_out_last_term,
   input  logic [1:0]  rsp_role_now,
   input  logic        rsp_last_of_run,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatches,
   output int          awaited,
   output logic [31:0] node_term
);

   // One outgoing message as the node should send it
   typedef struct packed {
      kind_type    kind;
      logic [2:0]  dest;
      logic [31:0] term;
      logic        ok;
      logic [31:0] last_index;
      logic [31:0] last_term;
      role_type    role;
      logic        last;
   } msg_type;

   msg_type outbox[$];     // messages predicted but not yet popped
   msg_type batch[$];      // messages caused by the current event
   int      fails = 0;

   // Register copy
   logic [2:0]  cfg_node;
   logic [3:0]  cfg_size;
   logic [23:0] cfg_eto;
   logic [15:0] cfg_hbi;
   logic [31:0] cfg_lidx;
   logic [31:0] cfg_lterm;

   // Node state
   role_type    role;
   logic [31:0] term;
   logic        voted;
   logic [2:0]  voted_for;
   logic [7:0]  votes;
   logic [23:0] elect_cnt;
   logic [15:0] hb_cnt;

   // Nodes taking part: size clamped to 1..8, widened to cover own id
   function automatic int unsigned cluster_span();
      int unsigned n;
      n = cfg_size;
      if (n == 0) n = 1;
      if (n > 8) n = 8;
      if (cfg_node >= n) n = cfg_node + 1;
      return n;
   endfunction

   function automatic bit quorum();
      int unsigned n;
      int unsigned c;
      n = cluster_span();
      c = 0;
      for (int i = 0; i < n; i++) c += votes[i];
      return c > n / 2;
   endfunction

   task automatic queue_msg(kind_type k, logic [2:0] dest, logic ok,
                            logic [31:0] li, logic [31:0] lt);
      batch.push_back('{k, dest, term, ok, li, lt, ROLE_FOLLOWER, 1'b0});
   endtask

   // One message to every peer
   task automatic fan_round(kind_type k);
      int unsigned n;
      n = cluster_span();
      for (int p = 0; p < n; p++) begin
         if (p != cfg_node) begin
            if (k == KIND_VOTE_REQ) queue_msg(k, 3'(p), 1'b0, cfg_lidx, cfg_lterm);
            else queue_msg(k, 3'(p), 1'b0, '0, '0);
         end
      end
   endtask

   task automatic take_lead();
      role = ROLE_LEADER;
      hb_cnt = '0;
      fan_round(KIND_HB);
   endtask

   task automatic demote(logic [31:0] t);
      term = t;
      voted = 1'b0;
      votes = '0;
      if (role != ROLE_FOLLOWER) elect_cnt = '0;
      role = ROLE_FOLLOWER;
   endtask

   task automatic store_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
         CSR_NODE_ID:       cfg_node = data[2:0];
         CSR_CLUSTER_SIZE:  cfg_size = data[3:0];
         CSR_ELECTION_TO:   cfg_eto = data[23:0];
         CSR_HB_INTERVAL:   cfg_hbi = data[15:0];
         CSR_OWN_LAST_IDX:  cfg_lidx = data;
         CSR_OWN_LAST_TERM: cfg_lterm = data;
         default: ;
      endcase
   endtask

   // Apply one event to the node state and queue the messages it causes
   task automatic predict_event(logic [2:0] mode, logic [31:0] mterm,
                                logic [2:0] sender, logic gr,
                                logic [31:0] cli, logic [31:0] clt);
      logic grant;
      logic free;
      logic fresh;
      grant = 1'b0;
      batch.delete();
      if (mode > MODE_HB_RSP) return;
      // any message from a later term forces a step down first
      if (mode != MODE_TICK && mterm > term) demote(mterm);
      case (mode)
         MODE_TICK: begin
            if (role == ROLE_LEADER) begin
               if (hb_cnt != 16'hFFFF) hb_cnt++;
               if (hb_cnt >= cfg_hbi) begin
                  hb_cnt = '0;
                  fan_round(KIND_HB);
               end
            end else begin
               if (elect_cnt != 24'hFFFFFF) elect_cnt++;
               if (elect_cnt >= cfg_eto) begin
                  // new election; term sticks at its maximum
                  if (term != '1) term++;
                  role = ROLE_CANDIDATE;
                  voted = 1'b1;
                  voted_for = cfg_node;
                  votes = 8'b1 << cfg_node;
                  elect_cnt = '0;
                  if (quorum()) take_lead();
                  else fan_round(KIND_VOTE_REQ);
               end
            end
         end
         MODE_VOTE_REQ: begin
            if (mterm >= term) begin
               free = !voted || voted_for == sender;
               fresh = clt > cfg_lterm || (clt == cfg_lterm && cli >= cfg_lidx);
               if (free && fresh) begin
                  grant = 1'b1;
                  voted = 1'b1;
                  voted_for = sender;
                  elect_cnt = '0;
               end
            end
            queue_msg(KIND_VOTE_RSP, sender, grant, '0, '0);
         end
         MODE_HB_REQ: begin
            if (mterm >= term) begin
               grant = 1'b1;
               role = ROLE_FOLLOWER;
               votes = '0;
               elect_cnt = '0;
            end
            queue_msg(KIND_HB_RSP, sender, grant, '0, '0);
         end
         MODE_VOTE_RSP: begin
            // counts only for a candidate in the same term
            if (role == ROLE_CANDIDATE && mterm == term && gr) begin
               if (sender < cluster_span()) votes[sender] = 1'b1;
               if (quorum()) take_lead();
            end
         end
         default: ;
      endcase
      foreach (batch[i]) begin
         batch[i].role = role;
         batch[i].last = (i == batch.size() - 1);
         outbox.push_back(batch[i]);
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         if (fails < 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         fails++;
      end
   endtask

   // Sample every channel at the clock edge
   always @(posedge clock) begin
      msg_type want;
      if (reset) begin
         cfg_node  = NODE_ID_RESET;
         cfg_size  = CLUSTER_SIZE_RESET;
         cfg_eto   = ELECTION_TO_RESET;
         cfg_hbi   = HB_INTERVAL_RESET;
         cfg_lidx  = '0;
         cfg_lterm = '0;
         role      = ROLE_FOLLOWER;
         term      = '0;
         voted     = 1'b0;
         voted_for = '0;
         votes     = '0;
         elect_cnt = '0;
         hb_cnt    = '0;
         node_term <= '0;
      end else begin
         // popped message against the oldest prediction
         if (pop && !empty) begin
            if (outbox.size() == 0) begin
               if (fails < 10)
                  $display("%0t: message with no transaction awaited (kind %0d, dest %0d)",
                           $time, rsp_kind, rsp_dest_id);
               fails++;
            end else begin
               want = outbox.pop_front();
               check_field("kind", want.kind, rsp_kind);
               check_field("dest_id", want.dest, rsp_dest_id);
               check_field("out_term", want.term, rsp_out_term);
               check_field("ok_flag", want.ok, rsp_ok_flag);
               check_field("out_last_index", want.last_index, rsp_out_last_index);
               check_field("out_last_term", want.last_term, rsp_out_last_term);
               check_field("role_now", want.role, rsp_role_now);
               check_field("last_of_run", want.last, rsp_last_of_run);
            end
         end
         if (csr_valid && csr_ready) store_register(csr_index, csr_data);
         if (push && !full)
            predict_event(req_mode, req_msg_term, req_sender_id, req_granted,
                          req_cand_last_index, req_cand_last_term);
         node_term <= term;
      end
      mismatches <= fails;
      awaited <= outbox.size();
   end

endmodule

[tb/raft_election_endpoint_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raft election endpoint testbench
// Drives events and register writes into the endpoint through several
// configurations and idling phases; the checker beside it predicts and
// compares every outgoing message.
// ----------------------------------------------------------------------------
module raft_election_endpoint_test;
   import ree_pkg::*;

   localparam int DRAIN_CYCLES = 16;

   // Spare register indexes, written to show they are ignored
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_mode = '0;
   logic [31:0] req_msg_term = '0;
   logic [2:0]  req_sender_id = '0;
   logic        req_granted = 1'b0;
   logic [31:0] req_cand_last_index = '0;
   logic [31:0] req_cand_last_term = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_dest_id;
   logic [31:0] rsp_out_term;
   logic        rsp_ok_flag;
   logic [31:0] rsp_out_last_index;
   logic [31:0] rsp_out_last_term;
   logic [1:0]  rsp_role_now;
   logic        rsp_last_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          mismatches;
   int          awaited;
   logic [31:0] node_term;

   int          send_idle = 0;    // percent of cycles the sender holds off
   int          recv_stall = 0;   // percent of cycles pop stays low
   logic [31:0] own_idx = '0;
   logic [31:0] own_trm = '0;

   raft_election_endpoint DUT (.*);

   raft_election_endpoint_checker checker_inst (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver side: random stalls
   always @(posedge clock) pop <= !reset && ($urandom_range(99) >= recv_stall);

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Register write; bits above the field width carry junk
   task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
      logic [31:0] junk;
      junk = $urandom;
      case (idx)
         CSR_NODE_ID:      value[31:3]  = junk[31:3];
         CSR_CLUSTER_SIZE: value[31:4]  = junk[31:4];
         CSR_ELECTION_TO:  value[31:24] = junk[31:24];
         CSR_HB_INTERVAL:  value[31:16] = junk[31:16];
         default: ;
      endcase
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(logic [2:0] node, logic [3:0] size, logic [23:0] eto,
                               logic [15:0] hbi, logic [31:0] lidx, logic [31:0] lterm);
      cfg_write(CSR_NODE_ID, 32'(node));
      cfg_write(CSR_CLUSTER_SIZE, 32'(size));
      cfg_write(CSR_ELECTION_TO, 32'(eto));
      cfg_write(CSR_HB_INTERVAL, 32'(hbi));
      cfg_write(CSR_OWN_LAST_IDX, lidx);
      cfg_write(CSR_OWN_LAST_TERM, lterm);
      own_idx = lidx;
      own_trm = lterm;
   endtask

   // One event transaction, after a random gap
   task automatic send_event(logic [2:0] mode, logic [31:0] mterm, logic [2:0] sender,
                             logic gr, logic [31:0] cli, logic [31:0] clt);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push                <= 1'b1;
      req_mode            <= mode;
      req_msg_term        <= mterm;
      req_sender_id       <= sender;
      req_granted         <= gr;
      req_cand_last_index <= cli;
      req_cand_last_term  <= clt;
      do @(posedge clock); while (full);
   endtask

   // Pause the sender until every predicted message has been popped
   task automatic hold_until_drained();
      push <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   // Idle point for register writes: drained, then let the block settle
   task automatic settle();
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Log position close to our own, so both sides of the freshness rule occur
   function automatic logic [31:0] near_value(logic [31:0] base);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) return base;
      if (r < 55) return base + 1;
      if (r < 70) return base - 1;
      return $urandom;
   endfunction

   // Random events, mostly in or just past the node's current term
   task automatic event_burst(int count);
      int unsigned pick;
      int unsigned r;
      logic [2:0]  mode;
      logic [31:0] hint;
      logic [31:0] mterm;
      logic [31:0] step;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 38) mode = MODE_TICK;
         else if (pick < 52) mode = MODE_VOTE_REQ;
         else if (pick < 62) mode = MODE_HB_REQ;
         else if (pick < 88) mode = MODE_VOTE_RSP;
         else if (pick < 95) mode = MODE_HB_RSP;
         else mode = 3'($urandom_range(7, 5));
         hint = node_term;
         r = $urandom_range(99);
         if (r < 50) mterm = hint;
         else if (r < 72) mterm = hint + 1;
         else if (r < 82) mterm = hint + $urandom_range(4, 2);
         else if (r < 93) begin
            step = $urandom_range(3, 1);
            mterm = (hint > step) ? hint - step : '0;
         end else mterm = $urandom;
         send_event(mode, mterm, 3'($urandom_range(7)), $urandom_range(99) < 85,
                    near_value(own_idx), near_value(own_trm));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: three nodes, fast timers, log at index 100 term 5
      apply_config(3'd0, 4'd3, 24'd2, 16'd2, 32'd100, 32'd5);
      send_event(MODE_TICK, 0, 0, 0, 0, 0);
      send_event(MODE_TICK, 0, 0, 0, 0, 0);           // election, term 1
      send_event(MODE_VOTE_RSP, 1, 1, 1, 0, 0);       // majority, leader
      send_event(MODE_TICK, 0, 0, 0, 0, 0);
      send_event(MODE_TICK, 0, 0, 0, 0, 0);           // heartbeat round
      send_event(MODE_VOTE_RSP, 1, 2, 1, 0, 0);       // leader ignores it
      send_event(MODE_HB_RSP, 1, 1, 0, 0, 0);
      send_event(MODE_VOTE_REQ, 1, 2, 0, 100, 5);     // already voted for self
      send_event(MODE_HB_REQ, 5, 2, 0, 0, 0);         // higher term, step down
      send_event(MODE_VOTE_REQ, 5, 1, 0, 100, 5);     // equal log, granted
      send_event(MODE_VOTE_REQ, 5, 2, 0, 100, 5);     // vote taken
      send_event(MODE_VOTE_REQ, 5, 1, 0, 100, 5);     // same voter again
      send_event(MODE_VOTE_REQ, 6, 3, 0, '1, 4);      // older log term
      send_event(MODE_VOTE_REQ, 7, 4, 0, 99, 5);      // shorter log
      send_event(MODE_VOTE_REQ, 8, 5, 0, 0, 6);       // newer log term
      send_event(MODE_HB_REQ, 3, 6, 0, 0, 0);         // stale leader
      send_event(MODE_VOTE_REQ, 2, 7, 0, 100, 5);     // stale candidate
      send_event(3'd5, 100, 1, 1, '1, '1);            // unknown modes
      send_event(3'd6, 100, 2, 1, '1, '1);
      send_event(3'd7, 100, 3, 1, '1, '1);
      send_event(MODE_VOTE_RSP, 8, 1, 1, 0, 0);       // follower ignores it
      send_event(MODE_HB_RSP, 20, 3, 0, 0, 0);        // reply with higher term
      send_event(MODE_VOTE_REQ, 20, 7, 1, '1, '1);
      send_event(MODE_TICK, 0, 0, 0, 0, 0);
      send_event(MODE_TICK, 0, 0, 0, 0, 0);           // election, term 21
      send_event(MODE_VOTE_RSP, 21, 2, 0, 0, 0);      // refused vote
      send_event(MODE_VOTE_RSP, 21, 6, 1, 0, 0);      // sender outside cluster
      send_event(MODE_VOTE_RSP, 21, 2, 1, 0, 0);      // leader
      settle();

      // Five nodes, no idling
      apply_config(3'd2, 4'd5, 24'd3, 16'd2, $urandom, $urandom_range(40));
      event_burst(40);
      settle();

      // Oversized cluster, zero timers; sender mostly idle
      apply_config(3'd7, 4'd15, 24'd0, 16'd0, $urandom_range(20), $urandom_range(20));
      send_idle = 84;
      event_burst(40);
      settle();

      // Own id beyond the cluster, longest interval; receiver mostly stalled
      apply_config(3'd5, 4'd2, 24'd1, 16'hFFFF, $urandom, $urandom);
      send_idle = 0;
      recv_stall = 84;
      event_burst(20);
      hold_until_drained();
      event_burst(20);
      settle();

      // Zero size counts as one node: instant leadership, both sides idling
      apply_config(3'd0, 4'd0, 24'd1, 16'd3, 32'd0, 32'd0);
      send_idle = 23;
      recv_stall = 23;
      event_burst(30);
      settle();

      // Full cluster, longest timeout, largest own log
      apply_config(3'd3, 4'd8, 24'hFFFFFF, 16'd1, '1, '1);
      send_idle = 0;
      recv_stall = 0;
      event_burst(30);
      settle();

      // Term at its maximum: a new election keeps it
      apply_config(3'd1, 4'd4, 24'd1, 16'd2, 32'd0, 32'd0);
      cfg_write(CSR_SPARE_6, $urandom);
      cfg_write(CSR_SPARE_7, $urandom);
      send_event(MODE_HB_REQ, '1, 0, 0, 0, 0);
      send_event(MODE_TICK, 0, 0, 0, 0, 0);
      send_event(MODE_VOTE_RSP, '1, 0, 1, 0, 0);
      send_event(MODE_VOTE_RSP, '1, 2, 1, 0, 0);
      send_event(MODE_TICK, 0, 0, 0, 0, 0);
      send_event(MODE_TICK, 0, 0, 0, 0, 0);
      recv_stall = 30;
      event_burst(12);

      recv_stall = 0;
      settle();
      if (mismatches == 0 && awaited == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
